// File: hdl/sync_length_block_deframer_core_macros.svh
// Assertion helpers used by the checker file.
`ifndef SYNC_LENGTH_BLOCK_DEFRAMER_CORE_MACROS_SVH
`define SYNC_LENGTH_BLOCK_DEFRAMER_CORE_MACROS_SVH

// Clocked property with asynchronous reset disable.
`define SLBD_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Stalled output beat must stay valid and keep the named signal.
`define SLBD_ASSERT_HOLD(label, clk, rst_n, vld, rdy, sig, msg) \
	`SLBD_ASSERT(label, clk, rst_n, (vld && !rdy) |=> (vld && $stable(sig)), msg)

`endif

// File: hdl/slbd_pkg.sv
package slbd_pkg;

	localparam logic [7:0]  SYNC_FIRST   = 8'h24;
	localparam logic [7:0]  SYNC_SECOND  = 8'h40;
	localparam logic [15:0] HEADER_BYTES = 16'd8;

	// header byte positions within a block
	localparam logic [15:0] POS_FIRST_BODY = 16'd2;
	localparam logic [15:0] POS_ID_LO      = 16'd4;
	localparam logic [15:0] POS_ID_HI      = 16'd5;
	localparam logic [15:0] POS_LEN_LO     = 16'd6;
	localparam logic [15:0] POS_LEN_HI     = 16'd7;

	// result queue depth, power of two, at least 2
	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic [15:0] byte_index;
		logic        last;
		logic [15:0] block_id;
		logic [15:0] block_length;
		logic        skipped_before;
		logic        length_error;
	} res_t;

	typedef struct packed {
		logic first;
		logic second;
	} push_t;

endpackage

// File: hdl/slbd_step.sv
module slbd_step import slbd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       beat,
	input  logic [7:0] data_byte,
	output push_t      push,
	output res_t       res0,
	output res_t       res1
);

	logic [7:0]  prev_q, prev_d;
	logic        in_block_q, in_block_d;
	logic [15:0] pos_q, pos_d;
	logic [15:0] id_q, id_d;
	logic [15:0] len_q, len_d;
	logic        skip_q, skip_d;

	logic [15:0] id_new, len_new;
	logic        blk_last, blk_err;

	always_comb begin
		id_new  = id_q;
		len_new = len_q;
		if (pos_q == POS_ID_LO)
			id_new = {id_q[15:8], data_byte};
		if (pos_q == POS_ID_HI)
			id_new = {data_byte, id_q[7:0]};
		if (pos_q == POS_LEN_LO)
			len_new = {len_q[15:8], data_byte};
		if (pos_q == POS_LEN_HI)
			len_new = {data_byte, len_q[7:0]};

		blk_err  = (pos_q == POS_LEN_HI) && (len_new < HEADER_BYTES);
		blk_last = blk_err ||
			((pos_q >= POS_LEN_HI) && (({1'b0, pos_q} + 17'd1) >= {1'b0, len_new}));
	end

	always_comb begin
		prev_d     = prev_q;
		in_block_d = in_block_q;
		pos_d      = pos_q;
		id_d       = id_q;
		len_d      = len_q;
		skip_d     = skip_q;
		push       = '0;
		res0       = '0;
		res1       = '0;

		if (!in_block_q) begin
			if (prev_q == SYNC_FIRST && data_byte == SYNC_SECOND) begin
				push.first           = beat;
				push.second          = beat;
				res0.out_byte        = SYNC_FIRST;
				res0.byte_index      = 16'd0;
				res0.skipped_before  = skip_q;
				res1.out_byte        = SYNC_SECOND;
				res1.byte_index      = 16'd1;
				res1.skipped_before  = skip_q;
				in_block_d           = 1'b1;
				pos_d                = POS_FIRST_BODY;
				id_d                 = '0;
				len_d                = '0;
				prev_d               = '0;
			end else begin
				// anything but '$' counts as discarded
				if (data_byte != SYNC_FIRST)
					skip_d = 1'b1;
				prev_d = data_byte;
			end
		end else begin
			push.first          = beat;
			res0.out_byte       = data_byte;
			res0.byte_index     = pos_q;
			res0.last           = blk_last;
			res0.block_id       = (pos_q >= POS_ID_HI) ? id_new : '0;
			res0.block_length   = (pos_q >= POS_LEN_HI) ? len_new : '0;
			res0.skipped_before = skip_q;
			res0.length_error   = blk_err;
			if (blk_last) begin
				in_block_d = 1'b0;
				pos_d      = '0;
				prev_d     = '0;
				id_d       = '0;
				len_d      = '0;
				skip_d     = 1'b0;
			end else begin
				pos_d = pos_q + 16'd1;
				id_d  = id_new;
				len_d = len_new;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q     <= '0;
			in_block_q <= 1'b0;
			pos_q      <= '0;
			id_q       <= '0;
			len_q      <= '0;
			skip_q     <= 1'b0;
		end else if (beat) begin
			prev_q     <= prev_d;
			in_block_q <= in_block_d;
			pos_q      <= pos_d;
			id_q       <= id_d;
			len_q      <= len_d;
			skip_q     <= skip_d;
		end
	end

endmodule

// File: hdl/slbd_queue.sv
module slbd_queue import slbd_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic  clk,
	input  logic  arst_n,
	input  push_t push,
	input  res_t  res0,
	input  res_t  res1,
	output logic  room,
	output logic  valid,
	input  logic  ready,
	output res_t  head
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	res_t          mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] count_q;
	logic [1:0]    n_push;
	logic          pop;

	assign n_push = {1'b0, push.first} + {1'b0, push.second};
	assign pop    = valid && ready;
	assign valid  = (count_q != '0);
	assign head   = mem_q[rd_q];
	// a beat may bring two results, so keep two slots free
	assign room   = (count_q <= CW'(DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.first)
			mem_q[wr_q] <= res0;
		if (push.second)
			mem_q[wr_q + AW'(1)] <= res1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + AW'(n_push);
			rd_q    <= rd_q + AW'(pop);
			count_q <= count_q + CW'(n_push) - CW'(pop);
		end
	end

endmodule

// File: hdl/sync_length_block_deframer_core.sv
// channel | handshake           | payload
// --------+---------------------+--------------------------------------------
// in      | in_valid / in_ready | data_byte
// out     | out_valid/out_ready | out_byte, byte_index, last, block_id,
//         |                     | block_length, skipped_before, length_error
//
// One input byte per cycle while in_ready is high; each byte is processed in the cycle it is taken.
// The '@' that completes sync yields two output beats, other block bytes one.
// Results wait in a small queue; in_ready is low while fewer than two slots
// are free, so throughput is one byte per cycle when out_ready stays high.
// Reset clears the deframer state and the queue.
module sync_length_block_deframer_core import slbd_pkg::*; #(
	parameter int QDEPTH = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic [15:0] byte_index,
	output logic        last,
	output logic [15:0] block_id,
	output logic [15:0] block_length,
	output logic        skipped_before,
	output logic        length_error
);

	push_t push;
	res_t  res0, res1, head;
	logic  beat;

	assign beat = in_valid && in_ready;

	slbd_step u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.beat      (beat),
		.data_byte (data_byte),
		.push      (push),
		.res0      (res0),
		.res1      (res1)
	);

	slbd_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.res0   (res0),
		.res1   (res1),
		.room   (in_ready),
		.valid  (out_valid),
		.ready  (out_ready),
		.head   (head)
	);

	assign out_byte       = head.out_byte;
	assign byte_index     = head.byte_index;
	assign last           = head.last;
	assign block_id       = head.block_id;
	assign block_length   = head.block_length;
	assign skipped_before = head.skipped_before;
	assign length_error   = head.length_error;

endmodule

// File: hdl/slbd_checker.sv
`include "sync_length_block_deframer_core_macros.svh"

module slbd_checker import slbd_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  out_byte,
	input logic [15:0] byte_index,
	input logic        last,
	input logic [15:0] block_id,
	input logic [15:0] block_length,
	input logic        length_error
);

	`SLBD_ASSERT_HOLD(a_out_hold, clk, arst_n, out_valid, out_ready, byte_index, "out beat changed while stalled")
	`SLBD_ASSERT(a_sync_first, clk, arst_n, (out_valid && byte_index == 16'd0) |-> (out_byte == SYNC_FIRST && !last), "index 0 is not the first sync byte")
	`SLBD_ASSERT(a_err_last, clk, arst_n, (out_valid && length_error) |-> (last && byte_index == POS_LEN_HI), "length error off the last header byte")
	`SLBD_ASSERT(a_early_hdr, clk, arst_n, (out_valid && byte_index < POS_ID_HI) |-> (block_id == 16'd0 && block_length == 16'd0 && !last), "header word shown before capture")

endmodule

bind sync_length_block_deframer_core slbd_checker u_checker (.*);
